### hdl/iub_pkg.sv
package iub_pkg;

    localparam int MAX_INTERVALS_DEF = 64;

    localparam logic CMD_BLOCK = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // work item that walks down the row of cells, one cell per cycle
    typedef struct packed {
        logic        vld;
        logic        cmd;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [32:0] blocked;
        logic        found;
        logic [31:0] best_low;
        logic [31:0] best_high;
        logic        has_free;
    } t_carry;

    // write-back broadcast to the cells
    typedef struct packed {
        logic        en;
        logic [31:0] lo;
        logic [31:0] hi;
    } t_wr;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_WRITE = 3'b100
    } t_state;

endpackage

### hdl/interval_union_block_table_top.sv
// Interval table with one cell per slot. A command is taken when start is high
// and busy is low; it walks the row of cells one slot per cycle, and the result
// is registered from the carry that leaves the last cell (a block command that stores
// its union then holds busy for a write-back state). A block command with
// range_low above range_high answers with all zeros on the next cycle. Each
// result is shown for one cycle under o_strobe and must be taken then.
module interval_union_block_table_top #(
    parameter int MAX_INTERVALS = iub_pkg::MAX_INTERVALS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cmd,
    input  logic [31:0] i_range_low,
    input  logic [31:0] i_range_high,
    output logic        o_strobe,
    output logic        o_table_full,
    output logic [31:0] o_first_free,
    output logic        o_none_free,
    output logic [32:0] o_free_count
);
    import iub_pkg::*;

    localparam int SLOT_W = $clog2(MAX_INTERVALS);

    t_carry            w_car  [0:MAX_INTERVALS];
    logic [SLOT_W-1:0] w_slot [0:MAX_INTERVALS];

    t_state            r_state;
    t_carry            r_inject;
    t_wr               r_wr;
    logic [SLOT_W-1:0] r_wr_slot;
    logic              r_strobe;
    logic              r_table_full;
    logic [31:0]       r_first_free;
    logic              r_none_free;
    logic [32:0]       r_free_count;

    t_carry            tail;
    logic [32:0]       free_cnt;
    logic              accept;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    assign w_car[0]  = r_inject;
    assign w_slot[0] = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_INTERVALS; g++) begin : g_cell
            iub_cell #(
                .SLOT_W (SLOT_W),
                .IDX    (g)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_car     (w_car[g]),
                .i_slot    (w_slot[g]),
                .o_car     (w_car[g+1]),
                .o_slot    (w_slot[g+1]),
                .i_wr      (r_wr),
                .i_wr_slot (r_wr_slot)
            );
        end
    endgenerate

    assign tail     = w_car[MAX_INTERVALS];
    assign free_cnt = 33'h1_0000_0000 - tail.blocked;

    always_ff @(posedge i_clk) begin
        r_strobe     <= 1'b0;
        r_inject.vld <= 1'b0;
        r_wr.en      <= 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if ((i_cmd == CMD_BLOCK) && (i_range_low > i_range_high)) begin
                        r_strobe     <= 1'b1;
                        r_table_full <= 1'b0;
                        r_first_free <= '0;
                        r_none_free  <= 1'b0;
                        r_free_count <= '0;
                    end else begin
                        r_inject <= '{vld: 1'b1, cmd: i_cmd, lo: i_range_low,
                                      hi: i_range_high, blocked: '0, found: 1'b0,
                                      best_low: '0, best_high: '0, has_free: 1'b0};
                        r_state  <= ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (tail.vld) begin
                    r_strobe <= 1'b1;
                    if (tail.cmd == CMD_BLOCK) begin
                        r_table_full <= !tail.has_free;
                        r_first_free <= '0;
                        r_none_free  <= 1'b0;
                        r_free_count <= '0;
                        r_wr.en      <= tail.has_free;
                        r_wr.lo      <= tail.lo;
                        r_wr.hi      <= tail.hi;
                        r_wr_slot    <= w_slot[MAX_INTERVALS];
                        r_state      <= tail.has_free ? ST_WRITE : ST_IDLE;
                    end else begin
                        r_table_full <= 1'b0;
                        r_free_count <= free_cnt;
                        r_none_free  <= (free_cnt == '0);
                        // first free is past the lowest interval only if it starts at zero
                        if ((free_cnt == '0) || !tail.found || (tail.best_low != '0)) begin
                            r_first_free <= '0;
                        end else begin
                            r_first_free <= tail.best_high + 32'd1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
            end
            ST_WRITE: begin
                r_state <= ST_IDLE;
            end
            default: begin
                r_state <= ST_IDLE;
            end
        endcase
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_strobe     <= 1'b0;
            r_inject.vld <= 1'b0;
            r_wr.en      <= 1'b0;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_table_full = r_table_full;
    assign o_first_free = r_first_free;
    assign o_none_free  = r_none_free;
    assign o_free_count = r_free_count;

endmodule

### hdl/iub_cell.sv
module iub_cell #(
    parameter int SLOT_W = 6,
    parameter int IDX    = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  iub_pkg::t_carry    i_car,
    input  logic [SLOT_W-1:0]  i_slot,
    output iub_pkg::t_carry    o_car,
    output logic [SLOT_W-1:0]  o_slot,
    input  iub_pkg::t_wr       i_wr,
    input  logic [SLOT_W-1:0]  i_wr_slot
);
    import iub_pkg::*;

    logic [31:0]       r_low;
    logic [31:0]       r_high;
    logic              r_valid;
    logic              n_valid;
    t_carry            r_car;
    t_carry            n_car;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic              hit;
    logic              wr_here;

    assign wr_here = i_wr.en && (i_wr_slot == SLOT_W'(IDX));

    // overlap or touch, tested at 33 bits
    assign hit = r_valid && (i_car.cmd == CMD_BLOCK) &&
                 !(({1'b0, r_low} > ({1'b0, i_car.hi} + 33'd1)) ||
                   (({1'b0, r_high} + 33'd1) < {1'b0, i_car.lo}));

    always_comb begin
        n_car  = i_car;
        n_slot = i_slot;
        if (i_car.cmd == CMD_BLOCK) begin
            if (hit) begin
                if (r_low < i_car.lo) begin
                    n_car.lo = r_low;
                end
                if (r_high > i_car.hi) begin
                    n_car.hi = r_high;
                end
            end
            if (!i_car.has_free && (!r_valid || hit)) begin
                n_car.has_free = 1'b1;
                n_slot         = SLOT_W'(IDX);
            end
        end else if (r_valid) begin
            n_car.blocked = i_car.blocked + ({1'b0, r_high} - {1'b0, r_low} + 33'd1);
            if (!i_car.found || (r_high < i_car.best_high)) begin
                n_car.found     = 1'b1;
                n_car.best_low  = r_low;
                n_car.best_high = r_high;
            end
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (wr_here) begin
            n_valid = 1'b1;
        end else if (i_car.vld && hit) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_car  <= n_car;
        r_slot <= n_slot;
        if (wr_here) begin
            r_low  <= i_wr.lo;
            r_high <= i_wr.hi;
        end
        if (!i_rst_n) begin
            r_car.vld <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_car  = r_car;
    assign o_slot = r_slot;

endmodule

### test/tb_interval_union_block_table_top.sv
module tb_interval_union_block_table_top;
    import iub_pkg::*;

    localparam int SLOTS = MAX_INTERVALS_DEF;
    localparam int N_RANDOM = 1600;
    localparam int STALL_LIMIT = 1000;
    localparam logic [32:0] SPACE = 33'h1_0000_0000;

    typedef struct {
        bit        full;
        bit [31:0] first_free;
        bit        none_free;
        bit [32:0] free_count;
    } t_answer;

    typedef struct {
        bit        cmd;
        bit [31:0] lo;
        bit [31:0] hi;
        bit        typed;
        t_answer   ans;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cmd;
    logic [31:0] i_range_low;
    logic [31:0] i_range_high;
    logic        o_strobe;
    logic        o_table_full;
    logic [31:0] o_first_free;
    logic        o_none_free;
    logic [32:0] o_free_count;

    interval_union_block_table_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_range_low(i_range_low), .i_range_high(i_range_high),
        .o_strobe(o_strobe), .o_table_full(o_table_full),
        .o_first_free(o_first_free), .o_none_free(o_none_free),
        .o_free_count(o_free_count)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // shadow copy of the interval table
    bit [31:0] shadow_lo [SLOTS];
    bit [31:0] shadow_hi [SLOTS];
    bit        shadow_used [SLOTS];

    t_answer pending_answers[$];
    int n_mismatch = 0;
    int n_results = 0;
    int n_blocks = 0;
    int n_queries = 0;
    int n_dropped = 0;
    int n_merged = 0;
    int n_reversed = 0;
    int idle_cycles = 0;
    bit progress;

    function automatic t_answer block_interval(bit [31:0] lo, bit [31:0] hi);
        t_answer a;
        int slot;
        a = '{default: 0};
        slot = -1;
        if (lo > hi) begin
            n_reversed++;
            return a;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (!shadow_used[i])
                continue;
            if ({1'b0, shadow_lo[i]} > {1'b0, hi} + 33'd1 ||
                {1'b0, shadow_hi[i]} + 33'd1 < {1'b0, lo})
                continue;
            if (shadow_lo[i] < lo)
                lo = shadow_lo[i];
            if (shadow_hi[i] > hi)
                hi = shadow_hi[i];
            shadow_used[i] = 0;
            n_merged++;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (!shadow_used[i]) begin
                slot = i;
                break;
            end
        end
        if (slot < 0) begin
            a.full = 1;
            n_dropped++;
            return a;
        end
        shadow_lo[slot] = lo;
        shadow_hi[slot] = hi;
        shadow_used[slot] = 1;
        return a;
    endfunction

    function automatic t_answer query_free();
        t_answer a;
        bit found;
        bit [31:0] low_lo;
        bit [31:0] low_hi;
        bit [63:0] blocked;
        bit [63:0] avail;
        a = '{default: 0};
        found = 0;
        low_lo = 0;
        low_hi = 0;
        blocked = 0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!shadow_used[i])
                continue;
            blocked += {32'd0, shadow_hi[i]} - {32'd0, shadow_lo[i]} + 64'd1;
            if (!found || shadow_hi[i] < low_hi) begin
                found = 1;
                low_lo = shadow_lo[i];
                low_hi = shadow_hi[i];
            end
        end
        avail = (blocked >= 64'h1_0000_0000) ? 64'd0 : 64'h1_0000_0000 - blocked;
        a.free_count = avail[32:0];
        if (avail == 0)
            a.none_free = 1;
        else if (found && low_lo == 0)
            a.first_free = low_hi + 32'd1;
        return a;
    endfunction

    // hold the item on the ports until it is taken, then predict its result
    task automatic send_item(bit cmd, bit [31:0] lo, bit [31:0] hi, bit typed,
                             t_answer typed_ans);
        t_answer a;
        start <= 1'b1;
        i_cmd <= cmd;
        i_range_low <= lo;
        i_range_high <= hi;
        do
            @(posedge i_clk);
        while (busy);
        if (cmd == CMD_QUERY) begin
            n_queries++;
            a = query_free();
        end else begin
            n_blocks++;
            a = block_interval(lo, hi);
        end
        pending_answers.push_back(typed ? typed_ans : a);
    endtask

    task automatic pause_sender(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_answer e;
        progress = start && !busy && i_rst_n;
        if (o_strobe && i_rst_n) begin
            progress = 1;
            n_results++;
            if (pending_answers.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result at %0t", $realtime);
            end else begin
                e = pending_answers.pop_front();
                if (o_table_full !== e.full || o_first_free !== e.first_free ||
                    o_none_free !== e.none_free || o_free_count !== e.free_count) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $write("mismatch at %0t: exp full=%0b first=%h none=%0b cnt=%h",
                               $realtime, e.full, e.first_free, e.none_free,
                               e.free_count);
                        $display(", got full=%0b first=%h none=%0b cnt=%h",
                                 o_table_full, o_first_free, o_none_free,
                                 o_free_count);
                    end
                end
            end
        end
        idle_cycles = progress ? 0 : idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no activity for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic t_answer ans(bit full, bit [31:0] ff, bit nf, bit [32:0] cnt);
        t_answer a;
        a.full = full;
        a.first_free = ff;
        a.none_free = nf;
        a.free_count = cnt;
        return a;
    endfunction

    function automatic t_row row(bit cmd, bit [31:0] lo, bit [31:0] hi, bit typed,
                                 t_answer a);
        t_row r;
        r.cmd = cmd;
        r.lo = lo;
        r.hi = hi;
        r.typed = typed;
        r.ans = a;
        return r;
    endfunction

    t_row opening[$];
    t_answer zeros;

    initial begin
        bit cmd;
        bit [31:0] lo;
        bit [31:0] hi;
        bit [31:0] span;
        int pick;
        int burst;
        int slot;
        int sent;
        int waited;

        start = 1'b0;
        i_cmd = CMD_BLOCK;
        i_range_low = '0;
        i_range_high = '0;
        i_rst_n = 1'b0;
        zeros = '{default: 0};
        foreach (shadow_used[i])
            shadow_used[i] = 0;

        opening.push_back(row(CMD_QUERY, 32'h0, 32'h0, 1, ans(0, 0, 0, SPACE)));
        opening.push_back(row(CMD_BLOCK, 32'h5, 32'h2, 1, zeros));
        opening.push_back(row(CMD_BLOCK, 32'hFFFF_FFFF, 32'h0, 1, zeros));
        opening.push_back(row(CMD_BLOCK, 32'h0, 32'h0, 1, zeros));
        opening.push_back(row(CMD_QUERY, 32'h0, 32'h0, 1, ans(0, 1, 0, SPACE - 1)));
        opening.push_back(row(CMD_BLOCK, 32'h1, 32'h1, 0, zeros));
        opening.push_back(row(CMD_BLOCK, 32'h3, 32'ha, 0, zeros));
        opening.push_back(row(CMD_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, zeros));
        // bridging item joins the two entries on either side
        opening.push_back(row(CMD_BLOCK, 32'h2, 32'h2, 0, zeros));
        opening.push_back(row(CMD_QUERY, 32'h0, 32'h0, 0, zeros));
        opening.push_back(row(CMD_BLOCK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, zeros));
        opening.push_back(row(CMD_BLOCK, 32'hFFFF_FFF0, 32'hFFFF_FFFE, 0, zeros));
        opening.push_back(row(CMD_QUERY, 32'h0, 32'hFFFF_FFFF, 0, zeros));
        opening.push_back(row(CMD_BLOCK, 32'h8000_0000, 32'h8000_FFFF, 0, zeros));
        opening.push_back(row(CMD_BLOCK, 32'h7FFF_0000, 32'h8000_0010, 0, zeros));
        opening.push_back(row(CMD_BLOCK, 32'h5555_5555, 32'hAAAA_AAAA, 0, zeros));
        opening.push_back(row(CMD_QUERY, 32'h5555_5555, 32'hAAAA_AAAA, 0, zeros));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (opening[k])
            send_item(opening[k].cmd, opening[k].lo, opening[k].hi,
                      opening[k].typed, opening[k].ans);
        pause_sender(3);

        sent = 0;
        while (sent < N_RANDOM) begin
            burst = $urandom_range(1, 30);
            for (int b = 0; b < burst && sent < N_RANDOM; b++) begin
                pick = $urandom_range(0, 99);
                lo = $urandom;
                hi = $urandom;
                cmd = CMD_BLOCK;
                if (pick < 35) begin
                    cmd = CMD_QUERY;
                end else if (pick < 60) begin
                    span = $urandom_range(0, 255);
                    hi = (lo > 32'hFFFF_FFFF - span) ? 32'hFFFF_FFFF : lo + span;
                end else if (pick < 88) begin
                    // touch or overlap a stored entry from one side
                    slot = $urandom_range(0, SLOTS - 1);
                    if (shadow_used[slot]) begin
                        span = $urandom_range(0, 64);
                        if ($urandom_range(0, 1)) begin
                            lo = (shadow_hi[slot] == 32'hFFFF_FFFF) ? shadow_hi[slot]
                                 : shadow_hi[slot] + $urandom_range(0, 1);
                            hi = (lo > 32'hFFFF_FFFF - span) ? 32'hFFFF_FFFF : lo + span;
                        end else begin
                            hi = (shadow_lo[slot] == 0) ? 32'h0
                                 : shadow_lo[slot] - $urandom_range(0, 1);
                            lo = (hi < span) ? 32'h0 : hi - span;
                        end
                    end else begin
                        hi = lo;
                    end
                end else if (pick < 97) begin
                    if (lo == hi)
                        hi = ~lo;
                    if (lo < hi) begin
                        span = lo;
                        lo = hi;
                        hi = span;
                    end
                end else if (lo > hi) begin
                    span = lo;
                    lo = hi;
                    hi = span;
                end
                send_item(cmd, lo, hi, 0, zeros);
                sent++;
                if (sent % 400 == 0) begin
                    // let the block drain completely before going on
                    start <= 1'b0;
                    while (pending_answers.size() != 0)
                        @(posedge i_clk);
                end
            end
            if ($urandom_range(0, 9) < 7)
                pause_sender($urandom_range(1, 15));
        end

        send_item(CMD_BLOCK, 32'h0, 32'hFFFF_FFFF, 0, zeros);
        send_item(CMD_QUERY, 32'h0, 32'h0, 1, ans(0, 0, 1, 33'd0));
        send_item(CMD_BLOCK, 32'h1234, 32'h5678, 1, zeros);
        send_item(CMD_QUERY, 32'hFFFF_FFFF, 32'h0, 1, ans(0, 0, 1, 33'd0));
        start <= 1'b0;

        waited = 0;
        while (pending_answers.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (80) @(posedge i_clk);

        $display("covered %0d block and %0d query items, %0d results seen",
                 n_blocks, n_queries, n_results);
        $display("entries merged %0d, inserts dropped on a full table %0d, reversed %0d",
                 n_merged, n_dropped, n_reversed);
        if (n_mismatch == 0 && pending_answers.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d results missing", n_mismatch,
                     pending_answers.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
